[rtl/tpr_pkg.sv]
`default_nettype none

package tpr_pkg;

   // sample and arithmetic widths
   localparam int SAMPLE_W = 8;
   localparam int ERR_W    = SAMPLE_W + 1;
   localparam int GAIN_W   = 16;
   localparam int ADDR_W   = 7;
   localparam int PROD_W   = GAIN_W + ERR_W;
   localparam int CTRL_W   = 40;
   localparam int SUM_W    = CTRL_W + 2;
   localparam int DUTY_W   = 7;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = GAIN_W;
   localparam int REQ_DATA_W  = 2 * SAMPLE_W;
   localparam int RSP_DATA_W  = 24;

   // register reset values (hundredths)
   localparam logic signed [GAIN_W-1:0] GAIN_CURRENT_RESET = 16'sd9924;
   localparam logic signed [GAIN_W-1:0] GAIN_PRIOR_RESET   = -16'sd9876;
   localparam logic [ADDR_W-1:0]        TARGET_ADDR_RESET  = '0;

   // duty mapping: control is in hundredths, duty = control / 1000
   localparam logic signed [CTRL_W-1:0] DUTY_FULL_LIMIT = 40'sd100000;
   localparam logic [DUTY_W-1:0]        DUTY_FULL       = 7'd100;
   // control/8 < 12500 on the linear range; q = (x * RECIP) >> RECIP_SHIFT
   // is exact for x / 125 over that range
   localparam int QUOT_IN_W   = 14;
   localparam int RECIP_W     = 15;
   localparam int RECIP_SHIFT = 21;
   localparam logic [RECIP_W-1:0] RECIP_125 = 15'd16778;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GAIN_CURRENT   = 2'd0,
      REG_GAIN_PRIOR     = 2'd1,
      REG_TARGET_ADDRESS = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_current;
      logic signed [GAIN_W-1:0] gain_prior;
      logic [ADDR_W-1:0]        target_address;
   } cfg_type;

   // pipeline control handed to each stage
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctrl_type;

   typedef struct packed {
      logic signed [PROD_W-1:0]   prod_current;
      logic signed [PROD_W-1:0]   prod_prior;
      logic signed [SAMPLE_W-1:0] temperature;
      logic                       fan_pulse;
   } front_type;

   typedef struct packed {
      logic signed [CTRL_W-1:0]   control;
      logic signed [SAMPLE_W-1:0] temperature;
      logic                       fan_pulse;
   } accum_type;

endpackage

`default_nettype wire

[rtl/temperature_pi_pwm_regulator_top.sv]
`default_nettype none

// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  req_tdata: raw_temperature, setpoint
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: duty_percent, fan_pulse,
//                                       slave_address, corrected_temperature
// csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// Four register stages: input, products, control sum, result. One word per
// cycle sustained while results are taken; each accepted word moves through the
// input, products, control sum and result registers in that order.
// The control recurrence closes on the add/saturate of the sum stage only.
// Reset (synchronous) clears the stage valids, the stored error and control,
// and loads the gain and address defaults.
// A held result stalls the whole pipe; req_tready drops only while the result
// register is full and not taken. csr_ready is always high.

module temperature_pi_pwm_regulator_top
   import tpr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   // [7:0] raw_temperature, [15:8] setpoint
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,

   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [6:0] duty_percent, [7] fan_pulse, [14:8] slave_address,
   // [22:15] corrected_temperature, [23] zero
   output      logic [RSP_DATA_W-1:0]  rsp_tdata,

   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type   cfg;
   front_type front;
   accum_type accum;

   // valid bit per stage
   logic in_vld_ff, in_vld_in;
   logic front_vld_ff, front_vld_in;
   logic accum_vld_ff, accum_vld_in;
   logic rsp_vld_ff, rsp_vld_in;

   logic advance;

   pipe_ctrl_type front_ctrl, accum_ctrl, duty_ctrl;

   // everything moves together unless a result is waiting and not taken
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_vld_ff;

   always_comb begin
      in_vld_in    = in_vld_ff;
      front_vld_in = front_vld_ff;
      accum_vld_in = accum_vld_ff;
      rsp_vld_in   = rsp_vld_ff;
      if (advance) begin
         in_vld_in    = req_tvalid;
         front_vld_in = in_vld_ff;
         accum_vld_in = front_vld_ff;
         rsp_vld_in   = accum_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         front_vld_ff <= 1'b0;
         accum_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         in_vld_ff    <= in_vld_in;
         front_vld_ff <= front_vld_in;
         accum_vld_ff <= accum_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   assign front_ctrl = '{advance: advance, valid: in_vld_ff};
   assign accum_ctrl = '{advance: advance, valid: front_vld_ff};
   assign duty_ctrl  = '{advance: advance, valid: accum_vld_ff};

   tpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // calibration, error, gain products
   tpr_error_stage u_error (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (front_ctrl),
      .raw_temperature (req_tdata[SAMPLE_W-1:0]),
      .setpoint        (req_tdata[2*SAMPLE_W-1:SAMPLE_W]),
      .cfg             (cfg),
      .front           (front)
   );

   // control sum with saturation, holds the control state
   tpr_accum u_accum (
      .clock (clock),
      .reset (reset),
      .ctrl  (accum_ctrl),
      .front (front),
      .accum (accum)
   );

   // duty mapping and result register
   tpr_duty u_duty (
      .clock          (clock),
      .ctrl           (duty_ctrl),
      .accum          (accum),
      .target_address (cfg.target_address),
      .rsp_data       (rsp_tdata)
   );

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_vld_ff)
      else $error("accepted word did not enter the pipe");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (accum_vld_ff && advance) |=> rsp_tvalid)
      else $error("finished word did not reach the result register");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[DUTY_W-1:0] <= DUTY_FULL)
      else $error("duty above full scale");

endmodule

`default_nettype wire

[rtl/tpr_csr.sv]
`default_nettype none

module tpr_csr
   import tpr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output      cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_GAIN_CURRENT:   cfg_in.gain_current   = csr_data;
            REG_GAIN_PRIOR:     cfg_in.gain_prior     = csr_data;
            REG_TARGET_ADDRESS: cfg_in.target_address = csr_data[ADDR_W-1:0];
            default:            ;  // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_current   <= GAIN_CURRENT_RESET;
         cfg_ff.gain_prior     <= GAIN_PRIOR_RESET;
         cfg_ff.target_address <= TARGET_ADDR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/tpr_error_stage.sv]
`default_nettype none

module tpr_error_stage
   import tpr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pipe_ctrl_type        ctrl,
   input  wire logic [SAMPLE_W-1:0]  raw_temperature,
   input  wire logic [SAMPLE_W-1:0]  setpoint,
   input  wire cfg_type              cfg,
   output      front_type            front
);

   function automatic logic signed [SAMPLE_W-1:0] calibrate(
      input logic signed [SAMPLE_W-1:0] t
   );
      logic signed [SAMPLE_W-1:0] r;
      r = t;
      if (t >= 14 && t <= 16)      r = t - SAMPLE_W'(4);
      else if (t >= 17 && t <= 22) r = t - SAMPLE_W'(3);
      else if (t >= 23 && t <= 27) r = t - SAMPLE_W'(2);
      else if (t >= 28 && t <= 31) r = t - SAMPLE_W'(1);
      return r;
   endfunction

   logic signed [SAMPLE_W-1:0] raw_ff, raw_in;
   logic signed [SAMPLE_W-1:0] sp_ff, sp_in;
   logic signed [ERR_W-1:0]    prev_err_ff, prev_err_in;
   front_type                  front_ff, front_in;

   logic signed [SAMPLE_W-1:0] temp;
   logic signed [ERR_W-1:0]    err;

   assign temp = calibrate(raw_ff);
   assign err  = ERR_W'(sp_ff) - ERR_W'(temp);

   always_comb begin
      raw_in      = raw_ff;
      sp_in       = sp_ff;
      prev_err_in = prev_err_ff;
      front_in    = front_ff;
      if (ctrl.advance) begin
         raw_in                = raw_temperature;
         sp_in                 = setpoint;
         front_in.prod_current = PROD_W'(cfg.gain_current) * PROD_W'(err);
         front_in.prod_prior   = PROD_W'(cfg.gain_prior) * PROD_W'(prev_err_ff);
         front_in.temperature  = temp;
         front_in.fan_pulse    = err[ERR_W-1];
         if (ctrl.valid) prev_err_in = err;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff   <= raw_in;
      sp_ff    <= sp_in;
      front_ff <= front_in;
      if (reset) prev_err_ff <= '0;
      else       prev_err_ff <= prev_err_in;
   end

   assign front = front_ff;

endmodule

`default_nettype wire

[rtl/tpr_accum.sv]
`default_nettype none

module tpr_accum
   import tpr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire pipe_ctrl_type ctrl,
   input  wire front_type     front,
   output      accum_type     accum
);

   localparam logic signed [CTRL_W-1:0] CTRL_MAX = {1'b0, {(CTRL_W-1){1'b1}}};
   localparam logic signed [CTRL_W-1:0] CTRL_MIN = {1'b1, {(CTRL_W-1){1'b0}}};

   logic signed [CTRL_W-1:0] prev_ctrl_ff, prev_ctrl_in;
   accum_type                accum_ff, accum_in;

   logic signed [SUM_W-1:0]  sum;
   logic signed [CTRL_W-1:0] sat;

   assign sum = SUM_W'(front.prod_current) + SUM_W'(front.prod_prior)
              + SUM_W'(prev_ctrl_ff);

   // saturate to the 40-bit range; windup otherwise kept
   always_comb begin
      if (sum[SUM_W-1:CTRL_W-1] == '0 || sum[SUM_W-1:CTRL_W-1] == '1) begin
         sat = sum[CTRL_W-1:0];
      end else if (sum[SUM_W-1]) begin
         sat = CTRL_MIN;
      end else begin
         sat = CTRL_MAX;
      end
   end

   always_comb begin
      prev_ctrl_in = prev_ctrl_ff;
      accum_in     = accum_ff;
      if (ctrl.advance) begin
         accum_in.control     = sat;
         accum_in.temperature = front.temperature;
         accum_in.fan_pulse   = front.fan_pulse;
         if (ctrl.valid) prev_ctrl_in = sat;
      end
   end

   always_ff @(posedge clock) begin
      accum_ff <= accum_in;
      if (reset) prev_ctrl_ff <= '0;
      else       prev_ctrl_ff <= prev_ctrl_in;
   end

   assign accum = accum_ff;

   // stored control only moves with a valid word
   a_ctrl_hold: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.advance && ctrl.valid) |=> $stable(prev_ctrl_ff))
      else $error("stored control changed without a valid word");

   a_ctrl_follow: assert property (@(posedge clock) disable iff (reset)
      (ctrl.advance && ctrl.valid) |=> prev_ctrl_ff == accum_ff.control)
      else $error("stored control differs from the forwarded value");

endmodule

`default_nettype wire

[rtl/tpr_duty.sv]
`default_nettype none

module tpr_duty
   import tpr_pkg::*;
(
   input  wire logic                  clock,
   input  wire pipe_ctrl_type         ctrl,
   input  wire accum_type             accum,
   input  wire logic [ADDR_W-1:0]     target_address,
   output      logic [RSP_DATA_W-1:0] rsp_data
);

   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;

   logic [QUOT_IN_W-1:0]         eighth;
   logic [QUOT_IN_W+RECIP_W-1:0] prod;
   logic [DUTY_W-1:0]            duty;

   // control/1000 = (control/8)/125 on the linear range
   assign eighth = accum.control[QUOT_IN_W+2:3];
   assign prod   = (QUOT_IN_W+RECIP_W)'(eighth) * (QUOT_IN_W+RECIP_W)'(RECIP_125);

   always_comb begin
      if (accum.control[CTRL_W-1] || accum.control == '0) begin
         duty = '0;
      end else if (accum.control >= DUTY_FULL_LIMIT) begin
         duty = DUTY_FULL;
      end else begin
         duty = prod[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (ctrl.advance) begin
         rsp_in = {1'b0, accum.temperature, target_address, accum.fan_pulse, duty};
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire
